// ----- rtl/periodic_min_image_displacement_defines.svh -----
// assertion macros shared by the periodic minimum image rtl
// no dependencies; included by the modules that carry checks
`ifndef PERIODIC_MIN_IMAGE_DISPLACEMENT_DEFINES_SVH
`define PERIODIC_MIN_IMAGE_DISPLACEMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check on every clock edge outside reset
`define PMID_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is low
`define PMID_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMID_ASSERT(label, clk, rst_n, prop, msg)
`define PMID_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

// ----- rtl/pmid_pkg.sv -----
// shared types and constants for the periodic minimum image block
// no dependencies
package pmid_pkg;

	localparam int N_STAGE = 6;
	localparam int REG_IDX_W = 3;
	localparam int DSQ_W = 63;

	localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_X  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_Z  = 3'd5;

	localparam logic [DSQ_W-1:0] DSQ_MAX = {DSQ_W{1'b1}};

	// per-stage load enables and valid bits, index 0 is stage 1
	typedef struct packed {
		logic [N_STAGE-1:0] load;
		logic [N_STAGE-1:0] vld;
	} pmid_ctl_t;

endpackage

// ----- rtl/pmid_axis.sv -----
// one axis of the minimum image datapath: difference, shift, wrap, square
// uses pmid_pkg and the assertion macros; stages 1 to 5 of the pipeline
`include "periodic_min_image_displacement_defines.svh"

module pmid_axis #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pmid_pkg::pmid_ctl_t                 ctl,
	input  logic        [COORD_WIDTH-2:0]       box_len,
	input  logic signed [COORD_WIDTH-1:0]       centre,
	input  logic signed [COORD_WIDTH-1:0]       pos,
	input  logic signed [COORD_WIDTH-1:0]       ref_pt,
	input  logic                                use_centre,
	output logic signed [COORD_WIDTH-1:0]       disp,
	output logic signed [COORD_WIDTH-1:0]       shift,
	output logic signed [COORD_WIDTH-1:0]       wrapped,
	output logic        [pmid_pkg::DSQ_W-1:0]   sq
);
	import pmid_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW-1:0] r_sel;
	logic signed [CW:0]   d_s1, d_s2;
	logic signed [CW-1:0] p_s1, p_s2;
	logic signed [CW+1:0] twice_d, len_e;
	logic signed [CW-1:0] len_cw, sh_next;
	logic signed [CW-1:0] sh_s2, sh_s3, sh_s4, sh_s5;
	logic signed [CW+1:0] dsum;
	logic signed [CW:0]   psum;
	logic signed [CW-1:0] disp_next, wrap_next;
	logic signed [CW-1:0] disp_s3, disp_s4, disp_s5;
	logic signed [CW-1:0] wrap_s3, wrap_s4, wrap_s5;
	logic        [CW-1:0] mag_s4;
	logic        [63:0]   mag64, prod;
	logic                 big;
	logic        [DSQ_W-1:0] sq_s5;

	// stage 1: pick the reference, take the raw difference
	assign r_sel = use_centre ? centre : ref_pt;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			d_s1 <= {pos[CW-1], pos} - {r_sel[CW-1], r_sel};
			p_s1 <= pos;
		end
	end

	// stage 2: compare 2d against the side length
	assign twice_d = {d_s1, 1'b0};
	assign len_e   = signed'({3'b000, box_len});
	assign len_cw  = signed'({1'b0, box_len});

	always_comb begin
		sh_next = '0;
		if (twice_d > len_e) begin
			sh_next = -len_cw;
		end else if (twice_d < -len_e) begin
			sh_next = len_cw;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			d_s2  <= d_s1;
			p_s2  <= p_s1;
			sh_s2 <= sh_next;
		end
	end

	// stage 3: apply the shift with saturation
	assign dsum = {d_s2[CW], d_s2} + {{2{sh_s2[CW-1]}}, sh_s2};
	assign psum = {p_s2[CW-1], p_s2} + {sh_s2[CW-1], sh_s2};

	always_comb begin
		if (dsum[CW+1:CW-1] == 3'b000 || dsum[CW+1:CW-1] == 3'b111) begin
			disp_next = dsum[CW-1:0];
		end else begin
			disp_next = dsum[CW+1] ? C_MIN : C_MAX;
		end
		if (psum[CW] == psum[CW-1]) begin
			wrap_next = psum[CW-1:0];
		end else begin
			wrap_next = psum[CW] ? C_MIN : C_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			disp_s3 <= disp_next;
			wrap_s3 <= wrap_next;
			sh_s3   <= sh_s2;
		end
	end

	// stage 4: magnitude, the most negative value maps to 2^(cw-1)
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			mag_s4  <= disp_s3[CW-1] ? CW'(-disp_s3) : CW'(disp_s3);
			disp_s4 <= disp_s3;
			wrap_s4 <= wrap_s3;
			sh_s4   <= sh_s3;
		end
	end

	// stage 5: square on a 32x32 multiplier, larger magnitudes saturate
	assign mag64 = 64'(mag_s4);
	assign big   = |mag64[63:32];
	assign prod  = {32'd0, mag64[31:0]} * {32'd0, mag64[31:0]};

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			sq_s5   <= (big || prod[63]) ? DSQ_MAX : prod[DSQ_W-1:0];
			disp_s5 <= disp_s4;
			wrap_s5 <= wrap_s4;
			sh_s5   <= sh_s4;
		end
	end

	assign disp    = disp_s5;
	assign shift   = sh_s5;
	assign wrapped = wrap_s5;
	assign sq      = sq_s5;

	`PMID_ASSERT(a_shift_legal, clk, arst_n, ctl.vld[1] |-> (sh_s2 == '0 || sh_s2 == len_cw || sh_s2 == -len_cw), "shift is not 0 or +/- side length")
	`PMID_ASSERT(a_zero_len_no_shift, clk, arst_n, (ctl.vld[1] && box_len == '0) |-> sh_s2 == '0, "shift applied with zero side length")
	`PMID_ASSERT(a_square_zero, clk, arst_n, (ctl.load[4] && ctl.vld[3]) |=> ((sq_s5 == '0) == ($past(mag_s4) == '0)), "square zero does not match magnitude zero")

endmodule

// ----- rtl/periodic_min_image_displacement.sv -----
// m_tvalid of a result rises when its word reaches the stage 6 output register
// throughput: one word per cycle if m_tready is high; six register stages (difference,
// shift, wrap, magnitude, 32x32 square, saturating sum), the square stage sets the depth
// each stage holds its word under back pressure, so a stall loses nothing
// arst_n clears all valid bits and the box length and centre registers to 0
// top level of the periodic minimum image block; uses pmid_pkg, pmid_axis
`include "periodic_min_image_displacement_defines.svh"

module periodic_min_image_displacement #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [pmid_pkg::REG_IDX_W-1:0]              cfg_index,
	input  logic [COORD_WIDTH-1:0]                      cfg_data,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// pos_x, pos_y, pos_z, ref_x, ref_y, ref_z, zero fill
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
	// use_centre
	input  logic                                        s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// disp_x, disp_y, disp_z, dist_sq, shift_x, shift_y, shift_z,
	// wrapped_x, wrapped_y, wrapped_z, zero fill
	output logic [((9*COORD_WIDTH+63+7)/8)*8-1:0]       m_tdata
);
	import pmid_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic        [CW-2:0]    box_len_q [3];
	logic signed [CW-1:0]    centre_q  [3];
	logic        [N_STAGE-1:0] vld_q, adv;
	pmid_ctl_t               ctl;
	logic signed [CW-1:0]    disp_a [3], shift_a [3], wrap_a [3];
	logic        [DSQ_W-1:0] sq_a [3];
	logic        [DSQ_W+1:0] sum3;
	logic signed [CW-1:0]    disp_s6 [3], shift_s6 [3], wrap_s6 [3];
	logic        [DSQ_W-1:0] dsq_s6;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_len_q[i] <= '0;
				centre_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_LEN_X: box_len_q[0] <= cfg_data[CW-2:0];
				REG_BOX_LEN_Y: box_len_q[1] <= cfg_data[CW-2:0];
				REG_BOX_LEN_Z: box_len_q[2] <= cfg_data[CW-2:0];
				REG_CENTRE_X:  centre_q[0]  <= cfg_data;
				REG_CENTRE_Y:  centre_q[1]  <= cfg_data;
				REG_CENTRE_Z:  centre_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes a new word when it is empty or its word moves on
	always_comb begin
		adv[N_STAGE-1] = !vld_q[N_STAGE-1] || m_tready;
		for (int k = N_STAGE-2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < N_STAGE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.load = adv;
	assign ctl.vld  = vld_q;
	assign s_tready = adv[0];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		pmid_axis #(
			.COORD_WIDTH(CW)
		) u_axis (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.box_len    (box_len_q[a]),
			.centre     (centre_q[a]),
			.pos        (s_tdata[a*CW +: CW]),
			.ref_pt     (s_tdata[(3+a)*CW +: CW]),
			.use_centre (s_tuser),
			.disp       (disp_a[a]),
			.shift      (shift_a[a]),
			.wrapped    (wrap_a[a]),
			.sq         (sq_a[a])
		);
	end

	// stage 6: saturating sum of the three squares, also the output register
	assign sum3 = (DSQ_W+2)'(sq_a[0]) + (DSQ_W+2)'(sq_a[1]) + (DSQ_W+2)'(sq_a[2]);

	always_ff @(posedge clk) begin
		if (adv[N_STAGE-1]) begin
			dsq_s6 <= (sum3 > (DSQ_W+2)'(DSQ_MAX)) ? DSQ_MAX : sum3[DSQ_W-1:0];
			for (int i = 0; i < 3; i++) begin
				disp_s6[i]  <= disp_a[i];
				shift_s6[i] <= shift_a[i];
				wrap_s6[i]  <= wrap_a[i];
			end
		end
	end

	assign m_tvalid = vld_q[N_STAGE-1];

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 3; i++) begin
			m_tdata[i*CW +: CW]                 = disp_s6[i];
			m_tdata[3*CW + DSQ_W + i*CW +: CW]  = shift_s6[i];
			m_tdata[6*CW + DSQ_W + i*CW +: CW]  = wrap_s6[i];
		end
		m_tdata[3*CW +: DSQ_W] = dsq_s6;
	end

	`PMID_ASSERT_RST(a_reset_clears, clk, !arst_n |-> vld_q == '0, "valid bits set during reset")
	`PMID_ASSERT(a_empty_takes, clk, arst_n, !vld_q[0] |-> s_tready, "empty first stage refuses a word")
	`PMID_ASSERT(a_hold_mid, clk, arst_n, (vld_q[2] && !adv[2]) |=> vld_q[2], "stalled stage dropped its word")

endmodule
